/* src/tdcs_pkg.sv */
package tdcs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SlotsDefault       = 8;
  localparam int unsigned MaxBindingsDefault = 16;

  // Field widths fixed by the event and result formats
  localparam int unsigned PosW    = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned TermW   = 16;
  localparam int unsigned BcountW = 5;
  localparam int unsigned IndexW  = 4;

  // Register indexes on the configuration port
  localparam logic RegTappingTerm  = 1'b0;
  localparam logic RegBindingCount = 1'b1;

  typedef enum logic {
    OP_PRESS   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INVOKED = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // Item travelling down the slot chain
  typedef struct packed {
    op_e                op;
    logic [PosW-1:0]    pos;
    logic [TimeW-1:0]   now;
    logic               done;
    status_e            status;
    logic [IndexW-1:0]  index;
  } tok_t;

endpackage

/* src/tdcs_cell.sv */
module tdcs_cell import tdcs_pkg::*; #(
  parameter int unsigned MAX_BINDINGS = MaxBindingsDefault,
  localparam int unsigned CntW = $clog2(MAX_BINDINGS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             pass_i,
  input  tok_t             tok_i,
  input  logic [TermW-1:0] term_i,
  input  logic [CntW-1:0]  nbind_i,
  output logic             tok_vld_o,
  output tok_t             tok_o
);

  logic             tok_vld_q;
  tok_t             tok_q, tok_d;
  logic             used_q, used_d;
  logic             held_q, held_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TimeW-1:0] last_q, last_d;

  logic             match, claim, restart;
  logic [CntW-1:0]  base_cnt, c0, c1;
  logic [TimeW-1:0] base_last, elapsed;
  logic [31:0]      c1_w, cnt_w;

  // Match this slot, claim it, end a release at a free slot, or hand the item on untouched
  always_comb begin
    tok_d  = tok_i;
    used_d = used_q;
    held_d = held_q;
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    last_d = last_q;

    match     = used_q && (pos_q == tok_i.pos);
    claim     = !used_q && (tok_i.op == OP_PRESS);
    base_cnt  = claim ? '0 : cnt_q;
    base_last = claim ? '0 : last_q;
    elapsed   = tok_i.now - base_last;
    restart   = (term_i != '0) && (elapsed > {{(TimeW-TermW){1'b0}}, term_i});
    c0        = restart ? '0 : base_cnt;
    // Wrap back to the first binding once the count reaches the limit
    c1        = (c0 >= nbind_i) ? CntW'(1) : c0 + CntW'(1);
    c1_w  = 32'(c1) - 32'd1;
    cnt_w = 32'(cnt_q) - 32'd1;

    if (!tok_i.done) begin
      if (!used_q && (tok_i.op == OP_RELEASE)) begin
        // Free slot reached: no slot holds this position
        tok_d.done = 1'b1;
      end else if (match || claim) begin
        tok_d.done = 1'b1;
        used_d     = 1'b1;
        pos_d      = tok_i.pos;
        if (tok_i.op == OP_PRESS) begin
          last_d = tok_i.now;
          if (nbind_i != '0) begin
            cnt_d        = c1;
            held_d       = 1'b1;
            tok_d.status = ST_INVOKED;
            tok_d.index  = c1_w[IndexW-1:0];
          end else begin
            cnt_d        = c0;
            held_d       = claim ? 1'b0 : held_q;
            tok_d.status = ST_IGNORED;
          end
        end else if (held_q) begin
          held_d = 1'b0;
          if ((nbind_i != '0) && (cnt_q != '0)) begin
            tok_d.status = ST_INVOKED;
            tok_d.index  = cnt_w[IndexW-1:0];
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      used_q    <= 1'b0;
      held_q    <= 1'b0;
    end else if (take_i) begin
      tok_vld_q <= 1'b1;
      used_q    <= used_d;
      held_q    <= held_d;
    end else if (pass_i) begin
      tok_vld_q <= 1'b0;
    end
  end

  // Slot payload and item register
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      tok_q  <= tok_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

/* src/tap_dance_cycle_selector.sv */
// An accepted item is registered in the entry stage and then in each slot cell in turn; it
// waits before the last cell while the output register holds an unread result. One item is
// in the chain at a time, and the next is taken while a result waits.
// Reset: asynchronous, active low; all slots free and released, both registers zero,
// no item in flight. Slot contents need no clearing pass.
module tap_dance_cycle_selector import tdcs_pkg::*; #(
  parameter int unsigned SLOTS        = SlotsDefault,
  parameter int unsigned MAX_BINDINGS = MaxBindingsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,   // key_position[7:0], now_ms[39:8]
  input  logic [0:0]         s_axis_tuser,   // operation[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // binding_index[3:0], zero fill
  output logic [2:0]         m_axis_tuser,   // status[1:0], press_not_release[2]
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [TermW-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_BINDINGS + 1);

  logic [TermW-1:0]   term_q;
  logic [BcountW-1:0] bcount_q;
  logic [CntW-1:0]    nbind;
  logic               busy_q;
  logic               s_fire;
  logic               acc_vld_q;
  tok_t               acc_q, acc_d;

  tok_t               stage_tok [SLOTS+1];
  logic [SLOTS:0]     stage_vld;
  logic [SLOTS-1:0]   take;
  logic [SLOTS-1:0]   pass;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q   <= '0;
      bcount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTappingTerm:  term_q   <= cfg_data_i;
        RegBindingCount: bcount_q <= cfg_data_i[BcountW-1:0];
        default:         term_q   <= term_q;
      endcase
    end
  end

  // Clamp the binding count to what the counters hold
  always_comb begin
    if (32'(bcount_q) > 32'(MAX_BINDINGS)) begin
      nbind = CntW'(MAX_BINDINGS);
    end else begin
      nbind = CntW'(bcount_q);
    end
  end

  // Take one item at a time
  assign s_axis_tready = !busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (s_fire) begin
      busy_q <= 1'b1;
    end else if (take[SLOTS-1]) begin
      busy_q <= 1'b0;
    end
  end

  // Entry stage: unmatched presses end as table full, releases as ignored
  always_comb begin
    acc_d.op     = op_e'(s_axis_tuser[0]);
    acc_d.pos    = s_axis_tdata[PosW-1:0];
    acc_d.now    = s_axis_tdata[PosW+TimeW-1:PosW];
    acc_d.done   = 1'b0;
    acc_d.status = (s_axis_tuser[0] == OP_PRESS) ? ST_NO_SLOT : ST_IGNORED;
    acc_d.index  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
    end else if (s_fire) begin
      acc_vld_q <= 1'b1;
    end else if (take[0]) begin
      acc_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      acc_q <= acc_d;
    end
  end

  assign stage_vld[0] = acc_vld_q;
  assign stage_tok[0] = acc_q;

  // Slot chain; the last cell's register is the output register
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == SLOTS - 1) begin : g_last
      assign take[k] = stage_vld[k] && (!stage_vld[k+1] || m_axis_tready);
      assign pass[k] = m_axis_tready;
    end else begin : g_mid
      assign take[k] = stage_vld[k];
      assign pass[k] = take[k+1];
    end

    tdcs_cell #(
      .MAX_BINDINGS(MAX_BINDINGS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .take_i   (take[k]),
      .pass_i   (pass[k]),
      .tok_i    (stage_tok[k]),
      .term_i   (term_q),
      .nbind_i  (nbind),
      .tok_vld_o(stage_vld[k+1]),
      .tok_o    (stage_tok[k+1])
    );
  end

  // Result
  assign m_axis_tvalid = stage_vld[SLOTS];
  assign m_axis_tdata  = {{(8-IndexW){1'b0}}, stage_tok[SLOTS].index};
  assign m_axis_tuser  = {(stage_tok[SLOTS].op == OP_PRESS), stage_tok[SLOTS].status};

  // At most one item walks the chain, and only while busy
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(stage_vld[SLOTS-1:0]) && (busy_q == (|stage_vld[SLOTS-1:0])))
    else $error("slot chain holds more than one item or busy flag is off");

  // An accepted item enters the entry stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> acc_vld_q)
    else $error("accepted item lost at entry");

  // A release never reports a full table
  a_release_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tuser[1:0] != ST_NO_SLOT))
    else $error("release reported as table full");

  // The last cell's take puts the result in the output register and clears busy
  a_land: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take[SLOTS-1] |=> (m_axis_tvalid && !busy_q))
    else $error("result did not reach output register");

endmodule
